// ===== hdl/dcpl_pkg.sv =====
// Package for the DAG critical path length unit.
// Holds sizes, request codes and the request and response payload types.
// No dependencies.
package dcpl_pkg;

   // Sizes of the stored problem.
   localparam int MAX_COURSES   = 256;
   localparam int MAX_PREREQS   = 1024;
   localparam int DURATION_BITS = 16;

   // Widths of the fields on the ports.
   localparam int COURSE_W   = 9;
   localparam int DUR_FIELD_W = 16;
   localparam int FINISH_W   = 24;

   // Derived widths.
   localparam int IDX_W       = $clog2(MAX_COURSES);
   localparam int COUNT_W     = $clog2(MAX_COURSES + 1);
   localparam int EDGE_IDX_W  = (MAX_PREREQS > 1) ? $clog2(MAX_PREREQS) : 1;
   localparam int EDGE_CNT_W  = $clog2(MAX_PREREQS + 1);
   localparam int INDEG_W     = EDGE_CNT_W;

   // Request codes.
   localparam logic [1:0] REQ_LOAD_DUR  = 2'd0;
   localparam logic [1:0] REQ_LOAD_EDGE = 2'd1;
   localparam logic [1:0] REQ_COMPUTE   = 2'd2;

   typedef struct packed {
      logic [1:0]             req_type;
      logic [COURSE_W-1:0]    course;
      logic [DUR_FIELD_W-1:0] duration;
      logic [COURSE_W-1:0]    prereq_from;
      logic [COURSE_W-1:0]    prereq_to;
   } dcpl_req_type;

   typedef struct packed {
      logic [FINISH_W-1:0] total_time;
      logic                edges_dropped;
   } dcpl_rsp_type;

endpackage

// ===== hdl/dag_critical_path_length_unit.sv =====
// DAG critical path length unit: stores a task graph and finds its longest path.
// Depends on dcpl_pkg for sizes, request codes and payload types.
//
// Usage. Requests arrive on the req_ channel (valid/stall); a transfer happens
// at a clock edge with req_valid high and req_stall low. A duration load is
// written with the transfer. An edge load stores the edge with the transfer;
// the target's indegree is read from its memory and written back incremented.
// A compute request produces exactly one transfer on the rsp_ channel with the
// longest finish time and the edge overflow flag; loads produce nothing.
// A compute walks the problem under a small sequencer: it seeds finish times
// and the ready queue, then for each course popped it scans the stored edges
// and relaxes each matching edge, then finds the queue empty and searches the
// finish times for the maximum over the course count in use; the result is
// registered and valid in the cycle after the search ends.
// The request channel is stalled during an edge increment and for the whole
// compute. A finished result sits in an output register; loads are taken
// while it waits, but a further compute is held off until it is taken.
// Reset (synchronous, active high) clears the memories' valid bits, the edge
// count, the overflow flag and the course count (to one). csr_ is always ready.
module dag_critical_path_length_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dcpl_pkg::dcpl_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dcpl_pkg::dcpl_rsp_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [dcpl_pkg::COURSE_W-1:0] csr_data
);
   import dcpl_pkg::*;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_EDGE  = 4'd1;
   localparam logic [3:0] ST_INIT  = 4'd2;
   localparam logic [3:0] ST_POP   = 4'd3;
   localparam logic [3:0] ST_POP_U = 4'd4;
   localparam logic [3:0] ST_POP_F = 4'd5;
   localparam logic [3:0] ST_SCAN  = 4'd6;
   localparam logic [3:0] ST_RELAX = 4'd7;
   localparam logic [3:0] ST_MAX   = 4'd8;

   // Memories. Durations and indegrees carry valid bits; an entry whose bit is
   // clear reads as zero. The edge list holds {source, target} course indexes.
   logic [DURATION_BITS-1:0] dur_mem   [MAX_COURSES];
   logic [INDEG_W-1:0]       indeg_mem [MAX_COURSES];
   logic [FINISH_W-1:0]      fin_mem   [MAX_COURSES];
   logic [IDX_W-1:0]         queue_mem [MAX_COURSES];
   logic [2*IDX_W-1:0]       edge_mem  [MAX_PREREQS];

   logic [MAX_COURSES-1:0] dur_vld_ff, dur_vld_in;
   logic [MAX_COURSES-1:0] indeg_vld_ff, indeg_vld_in;

   // Control registers.
   logic [3:0]            state_ff, state_in;
   logic [COURSE_W-1:0]   cc_ff, cc_in;
   logic [COUNT_W-1:0]    n_ff, n_in;
   logic [COUNT_W-1:0]    idx_ff, idx_in;
   logic [COUNT_W-1:0]    head_ff, head_in;
   logic [COUNT_W-1:0]    tail_ff, tail_in;
   logic [EDGE_CNT_W-1:0] e_ff, e_in;
   logic [EDGE_CNT_W-1:0] edge_total_ff, edge_total_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [IDX_W-1:0]    u_ff, u_in;
   logic [IDX_W-1:0]    v_ff, v_in;
   logic [FINISH_W-1:0] fin_u_ff, fin_u_in;
   logic [FINISH_W-1:0] best_ff, best_in;
   dcpl_rsp_type        rsp_data_ff, rsp_data_in;

   // Registered read data.
   logic [DURATION_BITS-1:0] dur_rd_ff;
   logic                     dur_vld_rd_ff;
   logic [INDEG_W-1:0]       indeg_rd_ff;
   logic                     indeg_vld_rd_ff;
   logic [FINISH_W-1:0]      fin_rd_ff;
   logic [IDX_W-1:0]         queue_rd_ff;
   logic [2*IDX_W-1:0]       edge_rd_ff;

   // Memory access controls.
   logic [IDX_W-1:0]         course_ra;
   logic [IDX_W-1:0]         fin_ra;
   logic [IDX_W-1:0]         queue_ra;
   logic                     dur_we;
   logic [IDX_W-1:0]         dur_wa;
   logic                     indeg_we;
   logic [IDX_W-1:0]         indeg_wa;
   logic [INDEG_W-1:0]       indeg_wd;
   logic                     fin_we;
   logic [IDX_W-1:0]         fin_wa;
   logic [FINISH_W-1:0]      fin_wd;
   logic                     queue_we;
   logic [IDX_W-1:0]         queue_wd;
   logic                     edge_we;
   logic                     clear_vld;

   // Shared datapath values.
   logic                     req_xfer;
   logic                     rsp_xfer;
   logic                     from_ok, to_ok, course_ok;
   logic [IDX_W-1:0]         from_idx, to_idx, course_idx;
   logic [COUNT_W-1:0]       n_eff;
   logic [DURATION_BITS-1:0] dur_val;
   logic [INDEG_W-1:0]       indeg_val;
   logic [IDX_W-1:0]         edge_src, edge_dst;
   logic [FINISH_W:0]        sum;
   logic [FINISH_W-1:0]      cand;
   logic                     queue_room;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) ||
                      (req_data.req_type == REQ_COMPUTE && rsp_valid_ff);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Course numbers on the ports start at one; stored indexes start at zero.
   assign course_ok  = (req_data.course != '0) &&
                       (req_data.course <= COURSE_W'(MAX_COURSES));
   assign from_ok    = (req_data.prereq_from != '0) &&
                       (req_data.prereq_from <= COURSE_W'(MAX_COURSES));
   assign to_ok      = (req_data.prereq_to != '0) &&
                       (req_data.prereq_to <= COURSE_W'(MAX_COURSES));
   assign course_idx = IDX_W'(req_data.course - COURSE_W'(1));
   assign from_idx   = IDX_W'(req_data.prereq_from - COURSE_W'(1));
   assign to_idx     = IDX_W'(req_data.prereq_to - COURSE_W'(1));

   // A course count above capacity acts as full capacity.
   assign n_eff = (cc_ff > COURSE_W'(MAX_COURSES)) ? COUNT_W'(MAX_COURSES)
                                                   : COUNT_W'(cc_ff);

   assign dur_val   = dur_vld_rd_ff   ? dur_rd_ff   : '0;
   assign indeg_val = indeg_vld_rd_ff ? indeg_rd_ff : '0;
   assign edge_src  = edge_rd_ff[2*IDX_W-1:IDX_W];
   assign edge_dst  = edge_rd_ff[IDX_W-1:0];

   // Saturating relaxation candidate: finish of the popped course plus the
   // target's own duration.
   assign sum  = {1'b0, fin_u_ff} + (FINISH_W+1)'(dur_val);
   assign cand = sum[FINISH_W] ? '1 : sum[FINISH_W-1:0];

   assign queue_room = tail_ff < COUNT_W'(MAX_COURSES);

   always_comb begin
      state_in      = state_ff;
      cc_in         = cc_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      e_in          = e_ff;
      edge_total_in = edge_total_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      fin_u_in      = fin_u_ff;
      best_in       = best_ff;
      rsp_data_in   = rsp_data_ff;
      course_ra     = to_idx;
      fin_ra        = '0;
      queue_ra      = head_ff[IDX_W-1:0];
      dur_we        = 1'b0;
      dur_wa        = course_idx;
      indeg_we      = 1'b0;
      indeg_wa      = v_ff;
      indeg_wd      = indeg_val + INDEG_W'(1);
      fin_we        = 1'b0;
      fin_wa        = idx_ff[IDX_W-1:0];
      fin_wd        = FINISH_W'(dur_val);
      queue_we      = 1'b0;
      queue_wd      = idx_ff[IDX_W-1:0];
      edge_we       = 1'b0;
      clear_vld     = 1'b0;

      if (csr_valid && csr_ready) begin
         cc_in = csr_data;
      end
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_data.req_type == REQ_COMPUTE) begin
               course_ra = '0;
            end
            if (req_xfer) begin
               unique case (req_data.req_type)
                  REQ_LOAD_DUR: begin
                     dur_we = course_ok;
                  end
                  REQ_LOAD_EDGE: begin
                     if (from_ok && to_ok) begin
                        if (edge_total_ff >= EDGE_CNT_W'(MAX_PREREQS)) begin
                           ovf_in = 1'b1;
                        end else begin
                           edge_we       = 1'b1;
                           edge_total_in = edge_total_ff + EDGE_CNT_W'(1);
                           v_in          = to_idx;
                           state_in      = ST_EDGE;
                        end
                     end
                  end
                  REQ_COMPUTE: begin
                     n_in     = n_eff;
                     idx_in   = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = ST_INIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EDGE: begin
            // Read of the target's indegree was issued with the transfer.
            indeg_we = 1'b1;
            state_in = ST_IDLE;
         end
         ST_INIT: begin
            if (idx_ff == n_ff) begin
               state_in = ST_POP;
            end else begin
               fin_we = 1'b1;
               if (indeg_val == '0 && queue_room) begin
                  queue_we = 1'b1;
                  tail_in  = tail_ff + COUNT_W'(1);
               end
               idx_in = idx_ff + COUNT_W'(1);
            end
            course_ra = idx_in[IDX_W-1:0];
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               idx_in   = '0;
               best_in  = '0;
               state_in = ST_MAX;
            end else begin
               head_in  = head_ff + COUNT_W'(1);
               state_in = ST_POP_U;
            end
         end
         ST_POP_U: begin
            u_in     = queue_rd_ff;
            fin_ra   = queue_rd_ff;
            state_in = ST_POP_F;
         end
         ST_POP_F: begin
            fin_u_in = fin_rd_ff;
            e_in     = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            course_ra = edge_dst;
            fin_ra    = edge_dst;
            if (e_ff == edge_total_ff) begin
               state_in = ST_POP;
            end else if (edge_src == u_ff && {1'b0, edge_dst} < n_ff) begin
               v_in     = edge_dst;
               state_in = ST_RELAX;
            end else begin
               e_in = e_ff + EDGE_CNT_W'(1);
            end
         end
         ST_RELAX: begin
            fin_wa   = v_ff;
            fin_wd   = cand;
            fin_we   = cand > fin_rd_ff;
            indeg_wd = indeg_val - INDEG_W'(1);
            if (indeg_val != '0) begin
               indeg_we = 1'b1;
               if (indeg_val == INDEG_W'(1) && queue_room) begin
                  queue_we = 1'b1;
                  queue_wd = v_ff;
                  tail_in  = tail_ff + COUNT_W'(1);
               end
            end
            e_in     = e_ff + EDGE_CNT_W'(1);
            state_in = ST_SCAN;
         end
         ST_MAX: begin
            if (idx_ff == n_ff) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.total_time    = best_ff;
               rsp_data_in.edges_dropped = ovf_ff;
               clear_vld                 = 1'b1;
               edge_total_in             = '0;
               ovf_in                    = 1'b0;
               state_in                  = ST_IDLE;
            end else begin
               if (fin_rd_ff > best_ff) begin
                  best_in = fin_rd_ff;
               end
               idx_in = idx_ff + COUNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The finish memory is read at the next course index while seeding
      // the maximum search and while it runs.
      if ((state_ff == ST_POP && head_ff == tail_ff) || state_ff == ST_MAX) begin
         fin_ra = idx_in[IDX_W-1:0];
      end
   end

   always_comb begin
      dur_vld_in   = dur_vld_ff;
      indeg_vld_in = indeg_vld_ff;
      if (clear_vld) begin
         dur_vld_in   = '0;
         indeg_vld_in = '0;
      end else begin
         if (dur_we) begin
            dur_vld_in[dur_wa] = 1'b1;
         end
         if (indeg_we) begin
            indeg_vld_in[indeg_wa] = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cc_ff         <= COURSE_W'(1);
         n_ff          <= '0;
         idx_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         e_ff          <= '0;
         edge_total_ff <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dur_vld_ff    <= '0;
         indeg_vld_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         cc_ff         <= cc_in;
         n_ff          <= n_in;
         idx_ff        <= idx_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         e_ff          <= e_in;
         edge_total_ff <= edge_total_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         dur_vld_ff    <= dur_vld_in;
         indeg_vld_ff  <= indeg_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      u_ff        <= u_in;
      v_ff        <= v_in;
      fin_u_ff    <= fin_u_in;
      best_ff     <= best_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Memories, each with one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (dur_we) begin
         dur_mem[dur_wa] <= req_data.duration[DURATION_BITS-1:0];
      end
      dur_rd_ff     <= dur_mem[course_ra];
      dur_vld_rd_ff <= dur_vld_ff[course_ra];
   end

   always_ff @(posedge clock) begin
      if (indeg_we) begin
         indeg_mem[indeg_wa] <= indeg_wd;
      end
      indeg_rd_ff     <= indeg_mem[course_ra];
      indeg_vld_rd_ff <= indeg_vld_ff[course_ra];
   end

   always_ff @(posedge clock) begin
      if (fin_we) begin
         fin_mem[fin_wa] <= fin_wd;
      end
      fin_rd_ff <= fin_mem[fin_ra];
   end

   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[tail_ff[IDX_W-1:0]] <= queue_wd;
      end
      queue_rd_ff <= queue_mem[queue_ra];
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_total_ff[EDGE_IDX_W-1:0]] <= {from_idx, to_idx};
      end
      edge_rd_ff <= edge_mem[e_in[EDGE_IDX_W-1:0]];
   end

   // Checks on the sequencer.
   a_head_behind_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff)
      else $error("ready queue head passed its tail");

   a_tail_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_EDGE) |-> tail_ff <= n_ff)
      else $error("more courses queued than are in use");

   a_edges_bounded: assert property (@(posedge clock) disable iff (reset)
      edge_total_ff <= EDGE_CNT_W'(MAX_PREREQS))
      else $error("edge count beyond capacity");

   a_result_from_max: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_MAX)
      else $error("result raised outside the maximum search");

   a_cleared_after_compute: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (edge_total_ff == '0 && !ovf_ff &&
                               dur_vld_ff == '0 && indeg_vld_ff == '0))
      else $error("problem data not cleared after a compute");

endmodule
